@@ hw/rtl/q2e_pkg.sv @@
// Package for the quaternion to Z-Y-X Euler angle block.
// Holds shared widths, constants, the CORDIC arctangent table and the front-end result struct.
package q2e_pkg;

    localparam int PROD_W   = 32;  // Q2.30 product
    localparam int SUM_W    = 33;  // sum of two products
    localparam int S_W      = 32;  // clamped asin argument, Q.30, must hold +2^30
    localparam int V_W      = 61;  // 1 - s*s, Q.60
    localparam int ROOT_W   = 32;  // isqrt result, Q.30
    localparam int CORDIC_W = 40;  // CORDIC x/y datapath
    localparam int ANG_W    = 32;  // angle accumulator, 2^32 = 2*pi
    localparam int ISQ_STAGES = 32;

    localparam logic signed [SUM_W-1:0] HALF_Q30 = SUM_W'(64'sd536870912);
    localparam logic signed [S_W-1:0]   ONE_Q30  = S_W'(64'sd1073741824);
    localparam logic [V_W-1:0]          ONE_Q60  = V_W'(64'd1) << 60;

    localparam logic [ANG_W-1:0] ANG_QUARTER  = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_NQUARTER = 32'hC000_0000;
    localparam logic [ANG_W-1:0] ANG_ROUND    = 32'h0000_8000;

    localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
    localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

    localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] num_b;
        logic signed [SUM_W-1:0] den_b;
        logic signed [SUM_W-1:0] num_h;
        logic signed [SUM_W-1:0] den_h;
        logic signed [S_W-1:0]   s;
        logic                    clamped;
    } t_front;

    // Binary angle with rounding: top 16 bits of z + 2^15.
    function automatic logic [15:0] to_angle16(input logic [ANG_W-1:0] z);
        logic [ANG_W-1:0] t;
        begin
            t = z + ANG_ROUND;
            return t[ANG_W-1:ANG_W-16];
        end
    endfunction

endpackage

@@ hw/rtl/q2e_ifs.sv @@
// Valid/ready channel interfaces for the quaternion input and the Euler angle output.
// Standalone; no package dependency.
interface q2e_quat_if;
    logic        valid;
    logic        ready;
    logic [15:0] quat_w;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
    logic        valid;
    logic        ready;
    logic [15:0] bank_angle;
    logic [15:0] pitch_angle;
    logic [15:0] heading_angle;
    logic        pitch_clamped;
    modport source (output valid, bank_angle, pitch_angle, heading_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, bank_angle, pitch_angle, heading_angle, pitch_clamped,
                    output ready);
endinterface

@@ hw/rtl/q2e_front.sv @@
// Front end: quaternion products, atan2 operands, clamped asin argument, 1 - s*s.
// Depends on q2e_pkg. Four register stages, advanced by i_en.
module q2e_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [15:0]     i_w,
    input  logic signed [15:0]     i_x,
    input  logic signed [15:0]     i_y,
    input  logic signed [15:0]     i_z,
    output logic                   o_valid,
    output q2e_pkg::t_front        o_front,
    output logic [q2e_pkg::V_W-1:0] o_v
);
    import q2e_pkg::*;

    logic [3:0] r_vld;
    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_zz, r_xy, r_wz, r_wy, r_xz;
    t_front r_f2, r_f3, r_f4;
    logic signed [2*S_W-1:0] r_ss;
    logic [V_W-1:0] r_v;
    t_front n_f2;
    logic signed [SUM_W:0] n_d;
    logic signed [SUM_W:0] n_sraw;

    always_comb begin
        n_f2.num_b = SUM_W'(r_yz) + SUM_W'(r_wx);
        n_f2.den_b = HALF_Q30 - (SUM_W'(r_xx) + SUM_W'(r_yy));
        n_f2.num_h = SUM_W'(r_xy) + SUM_W'(r_wz);
        n_f2.den_h = HALF_Q30 - (SUM_W'(r_yy) + SUM_W'(r_zz));
        n_d    = (SUM_W+1)'(r_wy) - (SUM_W+1)'(r_xz);
        n_sraw = n_d <<< 1;
        if (n_sraw > (SUM_W+1)'(ONE_Q30)) begin
            n_f2.s = ONE_Q30;
            n_f2.clamped = 1'b1;
        end else if (n_sraw < -(SUM_W+1)'(ONE_Q30)) begin
            n_f2.s = -ONE_Q30;
            n_f2.clamped = 1'b1;
        end else begin
            n_f2.s = S_W'(n_sraw);
            n_f2.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_wy <= i_w * i_y;
            r_xz <= i_x * i_z;
            r_f2 <= n_f2;
            r_f3 <= r_f2;
            r_ss <= r_f2.s * r_f2.s;
            r_f4 <= r_f3;
            r_v  <= ONE_Q60 - V_W'(r_ss);
        end
    end

    assign o_valid = r_vld[3];
    assign o_front = r_f4;
    assign o_v     = r_v;
endmodule

@@ hw/rtl/q2e_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband carried alongside.
// Depends on q2e_pkg.
module q2e_isqrt #(
    parameter int SW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [q2e_pkg::V_W-1:0]    i_v,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [q2e_pkg::ROOT_W-1:0] o_root,
    output logic [SW-1:0]              o_side
);
    import q2e_pkg::*;

    logic        s_vld  [ISQ_STAGES+1];
    logic [63:0] s_v    [ISQ_STAGES+1];
    logic [63:0] s_res  [ISQ_STAGES+1];
    logic [SW-1:0] s_side [ISQ_STAGES+1];

    assign s_vld[0]  = i_valid;
    assign s_v[0]    = 64'(i_v);
    assign s_res[0]  = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic          r_vld;
        logic [63:0]   r_v, r_res;
        logic [SW-1:0] r_side;
        logic [63:0]   n_trial;

        assign n_trial = s_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= s_side[k];
                if (s_v[k] >= n_trial) begin
                    r_v   <= s_v[k] - n_trial;
                    r_res <= (s_res[k] >> 1) + BIT;
                end else begin
                    r_v   <= s_v[k];
                    r_res <= s_res[k] >> 1;
                end
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_v[k+1]    = r_v;
        assign s_res[k+1]  = r_res;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_vld[ISQ_STAGES];
    assign o_root  = s_res[ISQ_STAGES][ROOT_W-1:0];
    assign o_side  = s_side[ISQ_STAGES];
endmodule

@@ hw/rtl/q2e_cordic.sv @@
// Unrolled CORDIC vectoring pipeline for atan2(y, x), one iteration per stage.
// Depends on q2e_pkg. Quadrant pre-rotation stage, then STEPS stages.
module q2e_cordic #(
    parameter int STEPS = 16,
    parameter int SW    = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [q2e_pkg::CORDIC_W-1:0] i_y,
    input  logic signed [q2e_pkg::CORDIC_W-1:0] i_x,
    input  logic [SW-1:0]                      i_side,
    output logic                               o_valid,
    output logic [q2e_pkg::ANG_W-1:0]          o_angle,
    output logic [SW-1:0]                      o_side
);
    import q2e_pkg::*;

    logic                       s_vld  [STEPS+1];
    logic signed [CORDIC_W-1:0] s_x    [STEPS+1];
    logic signed [CORDIC_W-1:0] s_y    [STEPS+1];
    logic [ANG_W-1:0]           s_z    [STEPS+1];
    logic                       s_zero [STEPS+1];
    logic [SW-1:0]              s_side [STEPS+1];

    logic                       r_vld0, r_zero0;
    logic signed [CORDIC_W-1:0] r_x0, r_y0;
    logic [ANG_W-1:0]           r_z0;
    logic [SW-1:0]              r_side0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_valid;
        end
    end

    // Left half plane: rotate by +-pi/2 and preload the angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side0 <= i_side;
            r_zero0 <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x0 <= i_y;
                    r_y0 <= -i_x;
                    r_z0 <= ANG_QUARTER;
                end else begin
                    r_x0 <= -i_y;
                    r_y0 <= i_x;
                    r_z0 <= ANG_NQUARTER;
                end
            end else begin
                r_x0 <= i_x;
                r_y0 <= i_y;
                r_z0 <= '0;
            end
        end
    end

    assign s_vld[0]  = r_vld0;
    assign s_x[0]    = r_x0;
    assign s_y[0]    = r_y0;
    assign s_z[0]    = r_z0;
    assign s_zero[0] = r_zero0;
    assign s_side[0] = r_side0;

    for (genvar g = 0; g < STEPS; g++) begin : g_iter
        logic                       r_vld, r_zero;
        logic signed [CORDIC_W-1:0] r_x, r_y;
        logic [ANG_W-1:0]           r_z;
        logic [SW-1:0]              r_side;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero <= s_zero[g];
                r_side <= s_side[g];
                if (s_y[g] >= 0) begin
                    r_x <= s_x[g] + (s_y[g] >>> g);
                    r_y <= s_y[g] - (s_x[g] >>> g);
                    r_z <= s_z[g] + ATAN_TAB[g];
                end else begin
                    r_x <= s_x[g] - (s_y[g] >>> g);
                    r_y <= s_y[g] + (s_x[g] >>> g);
                    r_z <= s_z[g] - ATAN_TAB[g];
                end
            end
        end

        assign s_vld[g+1]  = r_vld;
        assign s_x[g+1]    = r_x;
        assign s_y[g+1]    = r_y;
        assign s_z[g+1]    = r_z;
        assign s_zero[g+1] = r_zero;
        assign s_side[g+1] = r_side;
    end

    assign o_valid = s_vld[STEPS];
    assign o_angle = s_zero[STEPS] ? '0 : s_z[STEPS];
    assign o_side  = s_side[STEPS];
endmodule

@@ hw/rtl/quaternion_to_euler_zyx.sv @@
// Top level: unit quaternion (Q1.15) to Z-Y-X Tait-Bryan binary angles.
// Depends on q2e_pkg, q2e_ifs, q2e_front, q2e_isqrt, q2e_cordic.
//
//   channel   dir  beat contents
//   i_quat    in   quat_w, quat_x, quat_y, quat_z (signed Q1.15)
//   o_euler   out  bank_angle, pitch_angle, heading_angle, pitch_clamped
//
// One beat in and one result beat out per cycle, in order, unless stalled.
// Beats pass the front end (products, operands, s*s, 1-s*s), the isqrt
// (one root bit per stage), the CORDIC and the output register.
// Reset is synchronous, active low; it clears only the valid bits.
// The whole pipeline advances when the output register is empty or its
// beat is taken; otherwise every stage holds, so nothing is lost or repeated.
module quaternion_to_euler_zyx #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    q2e_quat_if.sink     i_quat,
    q2e_euler_if.source  o_euler
);
    import q2e_pkg::*;

    logic   w_en;
    logic   fr_valid;
    t_front fr_data;
    logic [V_W-1:0] fr_v;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_front            sq_side;

    logic             cb_valid;
    logic [ANG_W-1:0] ang_b, ang_p, ang_h;
    logic             p_clamped;

    logic        r_out_vld;
    logic [15:0] r_bank, r_pitch, r_heading;
    logic        r_clamped;

    logic signed [15:0] n_praw;
    logic signed [15:0] n_pitch;

    // Global stall: advance when the output slot is free or being drained.
    assign w_en = !r_out_vld || o_euler.ready;
    assign i_quat.ready = w_en;

    q2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_quat.valid),
        .i_w     (i_quat.quat_w),
        .i_x     (i_quat.quat_x),
        .i_y     (i_quat.quat_y),
        .i_z     (i_quat.quat_z),
        .o_valid (fr_valid),
        .o_front (fr_data),
        .o_v     (fr_v)
    );

    // cos(pitch) = sqrt(1 - s^2); the atan2 operands ride along as sideband.
    q2e_isqrt #(.SW($bits(t_front))) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (fr_valid),
        .i_v     (fr_v),
        .i_side  (fr_data),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Three CORDIC pipelines run in lockstep; pitch carries the clamp flag.
    q2e_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sq_valid),
        .i_y     (CORDIC_W'(sq_side.num_b)),
        .i_x     (CORDIC_W'(sq_side.den_b)),
        .i_side  (1'b0),
        .o_valid (),
        .o_angle (ang_b),
        .o_side  ()
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sq_valid),
        .i_y     (CORDIC_W'(sq_side.s)),
        .i_x     (CORDIC_W'({1'b0, sq_root})),
        .i_side  (sq_side.clamped),
        .o_valid (cb_valid),
        .o_angle (ang_p),
        .o_side  (p_clamped)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sq_valid),
        .i_y     (CORDIC_W'(sq_side.num_h)),
        .i_x     (CORDIC_W'(sq_side.den_h)),
        .i_side  (1'b0),
        .o_valid (),
        .o_angle (ang_h),
        .o_side  ()
    );

    // Pitch: round to 16 bits, then limit CORDIC residual to +-pi/2.
    always_comb begin
        n_praw = signed'(to_angle16(ang_p));
        if (n_praw > PITCH_MAX) begin
            n_pitch = PITCH_MAX;
        end else if (n_praw < PITCH_MIN) begin
            n_pitch = PITCH_MIN;
        end else begin
            n_pitch = n_praw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= cb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bank    <= to_angle16(ang_b);
            r_pitch   <= n_pitch;
            r_heading <= to_angle16(ang_h);
            r_clamped <= p_clamped;
        end
    end

    assign o_euler.valid         = r_out_vld;
    assign o_euler.bank_angle    = r_bank;
    assign o_euler.pitch_angle   = r_pitch;
    assign o_euler.heading_angle = r_heading;
    assign o_euler.pitch_clamped = r_clamped;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($signed(r_pitch) <= PITCH_MAX && $signed(r_pitch) >= PITCH_MIN))
        else $error("pitch out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_vld)
        else $error("output valid right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_euler.ready) |-> !i_quat.ready)
        else $error("input taken while pipeline stalled");
endmodule

@@ bench/quaternion_to_euler_zyx_tb.sv @@
// Self-checking bench for quaternion_to_euler_zyx: directed table plus random quaternions.
// Depends on q2e_pkg, q2e_ifs and the RTL; predicts angles with its own CORDIC model.
module quaternion_to_euler_zyx_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import q2e_pkg::*;

    localparam int STEPS    = 16;
    localparam int LATENCY  = 4 + 32 + STEPS + 2;
    localparam int LIMIT    = 400000;
    localparam int N_RAND   = 1950;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [15:0] bank;
        logic [15:0] pitch;
        logic [15:0] heading;
        logic        clamped;
    } t_euler;

    typedef struct {
        logic [15:0] w, x, y, z;
        bit          has_gold;   // typed-in result present
        t_euler      gold;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    q2e_quat_if  quat_ch ();
    q2e_euler_if euler_ch ();

    quaternion_to_euler_zyx #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_quat(quat_ch.sink), .o_euler(euler_ch.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    t_euler angles_due[$];
    int     n_errors = 0;
    int     cycle = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_go = 0;     // set once by the stimulus to start the long hold-off
    bit     hold_done = 0;
    int     hold_count = 0;  // long receiver hold-off, counted below

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;   // longint is signed, so this floors
    endfunction

    function automatic logic [31:0] vector_angle(longint ny, longint nx);
        logic [31:0] acc;
        longint t, ax, ay;
        acc = 0;
        ax = nx;
        ay = ny;
        if (ax == 0 && ay == 0) return 0;
        // left half plane: pre-rotate by a quarter turn
        if (ax < 0) begin
            t = ax;
            if (ay >= 0) begin
                ax = ay; ay = -t; acc = ANG_QUARTER;
            end else begin
                ax = -ay; ay = t; acc = ANG_NQUARTER;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            t = ax;
            if (ay >= 0) begin
                ax = ax + floor_shr(ay, i);
                ay = ay - floor_shr(t, i);
                acc = acc + ATAN_TAB[i];
            end else begin
                ax = ax - floor_shr(ay, i);
                ay = ay + floor_shr(t, i);
                acc = acc - ATAN_TAB[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] round_angle(logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h8000;
        return t[31:16];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_euler euler_of(logic [15:0] qw, logic [15:0] qx,
                                        logic [15:0] qy, logic [15:0] qz);
        longint w, x, y, z, num, den, s, p;
        longint unsigned c;
        t_euler r;
        w = longint'($signed(qw));
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));
        r.clamped = 0;
        num = y * z + w * x;
        den = (64'sd1 <<< 29) - (x * x + y * y);
        r.bank = round_angle(vector_angle(num, den));
        s = 2 * (w * y - x * z);
        if (s > (64'sd1 <<< 30)) begin
            s = 64'sd1 <<< 30; r.clamped = 1;
        end
        if (s < -(64'sd1 <<< 30)) begin
            s = -(64'sd1 <<< 30); r.clamped = 1;
        end
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        p = longint'($signed(round_angle(vector_angle(s, longint'(c)))));
        if (p > 16384) p = 16384;
        if (p < -16384) p = -16384;
        r.pitch = p[15:0];
        num = x * y + w * z;
        den = (64'sd1 <<< 29) - (y * y + z * z);
        r.heading = round_angle(vector_angle(num, den));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Directed table. Gold values only where obvious:
    // identity gives all zero; all-zero quaternion gives bank/heading
    // atan2(0,0.5)=0; full-scale w and y overflow asin and clamp.
    // ---------------------------------------------------------------
    t_row rows[$];

    task automatic add_row(int w, int x, int y, int z, bit g = 0, t_euler e = '0);
        t_row r;
        r.w = w[15:0]; r.x = x[15:0]; r.y = y[15:0]; r.z = z[15:0];
        r.has_gold = g;
        r.gold = e;
        rows.insert(rows.size(), r);
    endtask

    task automatic build_table();
        add_row(32767, 0, 0, 0, 1, '{16'd0, 16'd0, 16'd0, 1'b0});   // near identity
        add_row(0, 0, 0, 0, 1, '{16'd0, 16'd0, 16'd0, 1'b0});       // zero quaternion
        add_row(-32768, -32768, -32768, -32768);                     // all most negative
        add_row(32767, 32767, 32767, 32767);
        add_row(32767, 0, 32767, 0);                                 // asin overflow, +
        add_row(32767, 0, -32768, 0);                                // asin overflow, -
        add_row(-32768, 0, 32767, 0);
        add_row(0, 32767, 0, 0);                                     // bank pi: left half plane
        add_row(0, 0, 0, 32767);                                     // heading pi
        add_row(0, 0, 32767, 0);                                     // y only: bank and heading pi
        add_row(23170, 23170, 0, 0);                                 // bank pi/2
        add_row(23170, -23170, 0, 0);                                // bank -pi/2
        add_row(23170, 0, 23170, 0);                                 // pitch pi/2
        add_row(23170, 0, -23170, 0);
        add_row(23170, 0, 0, 23170);
        add_row(23170, 0, 0, -23170);
        add_row(16384, 16384, 16384, 16384);
        add_row(16384, -16384, 16384, -16384);
        add_row(0, -32768, 32767, 0);
        add_row(-1, 1, -1, 1);
        add_row(1, 0, 0, -32768);
        add_row(32767, -32768, 0, 0);                                // left half, y<0 side
        add_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);             // toggle every bit
        add_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    endtask

    // ---------------------------------------------------------------
    // Random quaternions: mostly near unit length, some raw noise
    // ---------------------------------------------------------------
    task automatic make_random(output logic [15:0] w, x, y, z);
        real a, b, c, d, n;
        if ($urandom_range(0, 3) == 0) begin
            w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end else begin
            a = real'($signed(16'($urandom)));
            b = real'($signed(16'($urandom)));
            c = real'($signed(16'($urandom)));
            d = real'($signed(16'($urandom)));
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            w = 16'($rtoi(a * 32767.0 / n));
            x = 16'($rtoi(b * 32767.0 / n));
            y = 16'($rtoi(c * 32767.0 / n));
            z = 16'($rtoi(d * 32767.0 / n));
        end
    endtask

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    task automatic send_beat(logic [15:0] w, x, y, z);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            quat_ch.valid <= 0;
            @(posedge i_clk);
        end
        quat_ch.valid  <= 1;
        quat_ch.quat_w <= w;
        quat_ch.quat_x <= x;
        quat_ch.quat_y <= y;
        quat_ch.quat_z <= z;
        angles_due.insert(angles_due.size(), euler_of(w, x, y, z));
        do @(posedge i_clk); while (!quat_ch.ready);
    endtask

    task automatic drain();
        quat_ch.valid <= 0;
        while (angles_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycle);
        n_errors++;
    endtask

    // Long hold-off length, counted in its own process
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_LEN - 1) hold_done <= 1;
        end
    end

    // Receiver: ready pattern, low in reset and during the long hold-off
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n || (hold_go && !hold_done)) begin
            euler_ch.ready <= 0;
        end else begin
            euler_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Checker: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_euler want;
        if (i_rst_n && euler_ch.valid && euler_ch.ready) begin
            if (angles_due.size() == 0) begin
                $display("unexpected result beat at cycle %0d", cycle);
                n_errors++;
            end else begin
                want = angles_due.pop_front();
                if (euler_ch.bank_angle !== want.bank)
                    report_mismatch("bank", euler_ch.bank_angle, want.bank);
                if (euler_ch.pitch_angle !== want.pitch)
                    report_mismatch("pitch", euler_ch.pitch_angle, want.pitch);
                if (euler_ch.heading_angle !== want.heading)
                    report_mismatch("heading", euler_ch.heading_angle, want.heading);
                if (euler_ch.pitch_clamped !== want.clamped)
                    report_mismatch("clamp", {15'd0, euler_ch.pitch_clamped},
                                    {15'd0, want.clamped});
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycle >= LIMIT) begin
            $display("quaternion_to_euler_zyx_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [15:0] w, x, y, z;
        t_euler pred;
        quat_ch.valid = 0;
        quat_ch.quat_w = 0;
        quat_ch.quat_x = 0;
        quat_ch.quat_y = 0;
        quat_ch.quat_z = 0;
        build_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed rows: typed-in gold must match the predictor too
        foreach (rows[i]) begin
            pred = euler_of(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
            if (rows[i].has_gold && pred !== rows[i].gold) begin
                $display("table row %0d disagrees with prediction", i);
                n_errors++;
            end
            send_beat(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
        end
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 19 : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 19 : 0;
            if (ph == 2) hold_go <= 1;   // fill the pipe and stall the input
            for (int k = 0; k < N_RAND / 4; k++) begin
                make_random(w, x, y, z);
                send_beat(w, x, y, z);
            end
            drain();   // sender pauses until everything is back
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("quaternion_to_euler_zyx_tb OK");
        else
            $display("quaternion_to_euler_zyx_tb NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_ifs.sv
hw/rtl/q2e_front.sv
hw/rtl/q2e_isqrt.sv
hw/rtl/q2e_cordic.sv
hw/rtl/quaternion_to_euler_zyx.sv
bench/quaternion_to_euler_zyx_tb.sv
